@@ rtl/lcar_pkg.sv @@
package lcar_pkg;

  // converter and field widths
  localparam int CONV_BITS = 24;
  localparam int RAW_W     = 24;
  localparam int WEIGHT_W  = 16;
  localparam int SCALE_W   = 16;

  // arithmetic widths: code / 100 < 2^(CONV_BITS-6), |diff| * 100 < 2^(VALUE_W+7)
  localparam int VALUE_W   = CONV_BITS - 6;
  localparam int DIFF_W    = VALUE_W + 1;
  localparam int PROD_W    = DIFF_W + 7;
  localparam int MAG_W     = VALUE_W + 7;
  localparam int DIV_W     = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // sequencer
  localparam int STEP_W = $clog2(CONV_BITS + 3);
  localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_GAIN  = STEP_W'(CONV_BITS + 2);

  localparam logic [CONV_BITS-1:0] SIGN_FLIP = {1'b1, {(CONV_BITS-1){1'b0}}};

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(945);
  localparam logic [SCALE_W-1:0] DIVISOR_100 = SCALE_W'(100);

  // command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_ZERO  = 2'd1;
  localparam logic [1:0] CMD_WEIGH = 2'd2;
  localparam logic [1:0] CMD_TARE  = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [1:0]           cmd;
    logic [CONV_BITS-1:0] code;
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] weight;
  } arith_res_t;

endpackage

@@ rtl/load_cell_adc_reader_with_tare.sv @@
// Load-cell converter reader with zero capture and tare. Every input item is
// one timing tick carrying the sampled data-out level and an optional command
// (capture zero, weigh, tare); every accepted item yields exactly one result
// item with the serial clock level, busy and done flags, the last raw reading
// in offset binary and the last weight. A command seen while idle starts a
// conversion: the clock stays low until data-out goes low, then 24 data pulses
// and one gain pulse follow, two ticks each. An ordinary tick's result is
// registered when the tick is accepted. The tick that ends a conversion runs
// the arithmetic through one bit-serial restoring divider that is used twice
// (code / 100, then the scaled difference / scale_hundredths). The result sits
// in an output register, so the next tick is taken while it waits, unless the
// divider is busy or the register is stalled. scale_hundredths is to be written
// through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce
// this. A value of zero acts as one.
module load_cell_adc_reader_with_tare (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [lcar_pkg::SCALE_W-1:0]  cfg_wr_data,
  // tick items in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic                          dt_level,
  // result items out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          sck_level,
  output logic                          busy_res,
  output logic                          done_res,
  output logic [lcar_pkg::RAW_W-1:0]    raw_code,
  output logic [lcar_pkg::WEIGHT_W-1:0] weight
);
  import lcar_pkg::*;

  // sequencer state
  logic [SCALE_W-1:0]   scale;
  logic [STEP_W-1:0]    step;
  logic [1:0]           pending;
  logic [CONV_BITS-1:0] shift_word;
  logic                 clock_out;
  logic [RAW_W-1:0]     last_raw;
  logic                 computing;

  logic [STEP_W-1:0]    step_next;
  logic [1:0]           pending_next;
  logic [CONV_BITS-1:0] shift_word_next;
  logic                 clock_out_next;
  logic                 finish;
  logic                 accept;
  logic [CONV_BITS-1:0] code;

  arith_req_t           req;
  arith_res_t           res;

  // hold off new ticks while the divider works or the result is stalled
  assign in_stall = computing || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign code     = shift_word ^ SIGN_FLIP;

  // one tick of the converter sequence
  always_comb begin
    step_next       = step;
    pending_next    = pending;
    shift_word_next = shift_word;
    clock_out_next  = clock_out;
    finish          = 1'b0;
    if (step == STEP_IDLE) begin
      clock_out_next = 1'b0;
      if (func != CMD_NONE) begin
        pending_next    = func;
        shift_word_next = '0;
        step_next       = STEP_WAIT;
      end
    end else if (step == STEP_WAIT) begin
      clock_out_next = 1'b0;
      if (!dt_level) begin
        step_next = STEP_FIRST;
      end
    end else if (step < STEP_GAIN) begin
      // high phase shifts, low phase samples the new bit
      if (!clock_out) begin
        clock_out_next  = 1'b1;
        shift_word_next = {shift_word[CONV_BITS-2:0], 1'b0};
      end else begin
        clock_out_next  = 1'b0;
        shift_word_next = {shift_word[CONV_BITS-1:1], dt_level};
        step_next       = step + STEP_W'(1);
      end
    end else if (step == STEP_GAIN) begin
      // extra pulse selects gain 128
      if (!clock_out) begin
        clock_out_next = 1'b1;
      end else begin
        clock_out_next = 1'b0;
        finish         = 1'b1;
        step_next      = STEP_IDLE;
      end
    end else begin
      clock_out_next = 1'b0;
      step_next      = STEP_IDLE;
    end
  end

  assign req.start = accept && finish;
  assign req.cmd   = pending;
  assign req.code  = code;

  lcar_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .scale (scale),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= SCALE_RESET;
      step       <= STEP_IDLE;
      pending    <= CMD_NONE;
      shift_word <= '0;
      clock_out  <= 1'b0;
      last_raw   <= '0;
      computing  <= 1'b0;
      out_valid  <= 1'b0;
      sck_level  <= 1'b0;
      busy_res   <= 1'b0;
      done_res   <= 1'b0;
      raw_code   <= '0;
      weight     <= '0;
    end else begin
      if (cfg_wr_en) begin
        scale <= cfg_wr_data;
      end
      // result holds while stalled, reloads on a plain tick or when the arithmetic ends
      out_valid <= (out_valid && out_stall) || (accept && !finish) || res.done;
      if (accept) begin
        step       <= step_next;
        pending    <= pending_next;
        shift_word <= shift_word_next;
        clock_out  <= clock_out_next;
        if (finish) begin
          // result waits for the arithmetic
          last_raw  <= RAW_W'(code);
          computing <= 1'b1;
        end else begin
          sck_level <= clock_out_next;
          busy_res  <= step_next != STEP_IDLE;
          done_res  <= 1'b0;
          raw_code  <= last_raw;
        end
      end
      if (res.done) begin
        computing <= 1'b0;
        sck_level <= 1'b0;
        busy_res  <= 1'b0;
        done_res  <= 1'b1;
        raw_code  <= last_raw;
        weight    <= res.weight;
      end
    end
  end

endmodule

@@ rtl/lcar_div.sv @@
module lcar_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lcar_pkg::DIV_W-1:0]   dividend,
  input  logic [lcar_pkg::SCALE_W-1:0] divisor,
  output logic                         done,
  output logic [lcar_pkg::DIV_W-1:0]   quotient
);
  import lcar_pkg::*;

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]     quo;
  logic [SCALE_W-1:0]   rem;
  logic [SCALE_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [SCALE_W:0]     shifted;
  logic [SCALE_W:0]     trial;
  logic                 fits;

  assign shifted  = {rem, quo[DIV_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse after the last quotient bit
      done <= !start && busy && cnt == DIV_CNT_W'(1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
    end
  end

endmodule

@@ rtl/lcar_arith.sv @@
module lcar_arith (
  input  logic                         clk,
  input  logic                         rst,
  input  lcar_pkg::arith_req_t         req,
  input  logic [lcar_pkg::SCALE_W-1:0] scale,
  output lcar_pkg::arith_res_t         res
);
  import lcar_pkg::*;

  localparam logic [2:0] A_IDLE   = 3'd0;
  localparam logic [2:0] A_DIV1   = 3'd1;
  localparam logic [2:0] A_MUL    = 3'd2;
  localparam logic [2:0] A_LAUNCH = 3'd3;
  localparam logic [2:0] A_DIV2   = 3'd4;

  logic [2:0]          state;
  logic [1:0]          cmd;
  logic [VALUE_W-1:0]  zero_offset;
  logic [WEIGHT_W-1:0] tare_offset;
  logic [DIFF_W-1:0]   diff;
  logic                neg;
  logic [MAG_W-1:0]    mag;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [SCALE_W-1:0]  div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;

  logic [VALUE_W-1:0]  value;
  logic [PROD_W-1:0]   diff_ext;
  logic [PROD_W-1:0]   prod;
  logic [WEIGHT_W-1:0] q_low;
  logic [WEIGHT_W-1:0] w_new;
  logic [SCALE_W-1:0]  scale_eff;

  assign scale_eff    = (scale == '0) ? SCALE_W'(1) : scale;
  assign div_start    = (state == A_IDLE && req.start) || state == A_LAUNCH;
  assign div_dividend = (state == A_LAUNCH) ? DIV_W'(mag) : DIV_W'(req.code);
  assign div_divisor  = (state == A_LAUNCH) ? scale_eff : DIVISOR_100;

  assign value    = div_quo[VALUE_W-1:0];
  assign diff_ext = {{(PROD_W-DIFF_W){diff[DIFF_W-1]}}, diff};
  // times 100 as 64 + 32 + 4
  assign prod     = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
  assign q_low    = div_quo[WEIGHT_W-1:0];
  // answer is -q - tare for signed q; q_low is the magnitude, neg the sign of the difference
  assign w_new    = neg ? (q_low - tare_offset) : (WEIGHT_W'(0) - q_low - tare_offset);

  lcar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= A_IDLE;
      cmd         <= CMD_NONE;
      zero_offset <= '0;
      tare_offset <= '0;
      res.done    <= 1'b0;
      res.weight  <= '0;
    end else begin
      // a zero capture ends after the first division, the rest after the second
      res.done <= div_done && (state == A_DIV2 || (state == A_DIV1 && cmd == CMD_ZERO));
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            cmd   <= req.cmd;
            state <= A_DIV1;
          end
        end
        A_DIV1: begin
          if (div_done) begin
            if (cmd == CMD_ZERO) begin
              zero_offset <= value;
              res.weight  <= '0;
              state       <= A_IDLE;
            end else begin
              diff  <= {1'b0, value} - {1'b0, zero_offset};
              state <= A_MUL;
            end
          end
        end
        A_MUL: begin
          neg   <= prod[PROD_W-1];
          mag   <= prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
          state <= A_LAUNCH;
        end
        A_LAUNCH: begin
          state <= A_DIV2;
        end
        A_DIV2: begin
          if (div_done) begin
            res.weight <= w_new;
            if (cmd == CMD_TARE) begin
              tare_offset <= w_new;
            end
            state <= A_IDLE;
          end
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule
